[rtl/core/pls_pkg.sv]
package pls_pkg;

    // Defaults for the top-level parameters
    localparam int CAPACITY_DEF   = 64;
    localparam int ITEM_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int CMD_W  = 2;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 7;

    // Stream packing, padded to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // Cells per leaf of the registered read tree
    localparam int GROUP = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_RETRIEVE = 2'd2
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Control broadcast to every cell for one request
    typedef struct packed {
        logic             ins;  // validated insert
        logic             rem;  // validated remove
        logic             rd;   // validated retrieve
        logic [POS_W-1:0] at;   // zero-based target index
    } cell_ctl_t;

endpackage

[rtl/core/positional_list_store_top.sv]
// Positional list store: an ordered list of up to CAPACITY items, addressed
// by 1-based position.
//   Request channel s_*: s_tuser carries the command (insert, remove,
//   retrieve), s_tdata the position and the new value.
//   Result channel m_*: one result per request, with the read value, a
//   status (ok, position out of range, list full) and the length after the
//   operation.
// Each item sits in its own cell of a chain; on an insert the cells behind
// the target take their left neighbor, on a remove the target and the cells
// behind it take their right neighbor, so the whole chain shifts at once.
// Retrieve runs through a two-level OR tree: leaves of GROUP cells are
// registered at accept, the root is folded into the output register.
// A request passes the tree stage, then the output register that drives
// m_tvalid. Throughput: one request per clock while m_tready is high.
// Reset clears the length and empties the pipeline; cell contents are left
// as they are and are only read where written.
// When the receiver stalls, the result holds in the output register, one
// more result waits in the tree stage, and s_tready then drops.
module positional_list_store_top #(
    parameter int CAPACITY   = pls_pkg::CAPACITY_DEF,
    parameter int ITEM_WIDTH = pls_pkg::ITEM_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // position [6:0], new_value [38:7], zero pad [39]
    input  logic [pls_pkg::S_TDATA_W-1:0] s_tdata,
    // command [1:0]
    input  logic [pls_pkg::CMD_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // read_value [31:0], status [33:32], length [40:34], zero pad [47:41]
    output logic [pls_pkg::M_TDATA_W-1:0] m_tdata
);
    import pls_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int NGRP  = (CAPACITY + GROUP - 1) / GROUP;

    // ---------------- request decode ----------------
    cmd_t                  cmd;
    logic [POS_W-1:0]      pos;
    logic [ITEM_WIDTH-1:0] new_item;
    logic                  s_accept;

    assign cmd      = cmd_t'(s_tuser);
    assign pos      = s_tdata[POS_W-1:0];
    assign new_item = ITEM_WIDTH'(s_tdata[POS_W +: VAL_W]);
    assign s_accept = s_tvalid && s_tready;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CMP_W-1:0] pos_w;
    logic [CMP_W-1:0] cnt_w;
    logic             pos_nz;
    logic             in_list;    // 1 .. length
    logic             in_ins;     // 1 .. length+1
    logic             full;
    logic             ins_ok;
    logic             rem_ok;
    logic             rd_ok;
    status_t          status;

    assign pos_w   = CMP_W'(pos);
    assign cnt_w   = CMP_W'(cnt_reg);
    assign pos_nz  = (pos != '0);
    assign in_list = pos_nz && (pos_w <= cnt_w);
    assign in_ins  = pos_nz && (pos_w <= cnt_w + CMP_W'(1));
    assign full    = (cnt_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        ins_ok = 1'b0;
        rem_ok = 1'b0;
        rd_ok  = 1'b0;
        status = ST_RANGE;
        unique case (cmd)
            CMD_INSERT:
            begin
                if (in_ins)
                begin
                    if (full)
                        status = ST_FULL;
                    else
                    begin
                        ins_ok = 1'b1;
                        status = ST_OK;
                    end
                end
            end
            CMD_REMOVE:
            begin
                if (in_list)
                begin
                    rem_ok = 1'b1;
                    status = ST_OK;
                end
            end
            CMD_RETRIEVE:
            begin
                if (in_list)
                begin
                    rd_ok  = 1'b1;
                    status = ST_OK;
                end
            end
            default:
            begin
                status = ST_RANGE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (s_accept && ins_ok)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (s_accept && rem_ok)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    // ---------------- chain of cells ----------------
    cell_ctl_t             ctl;
    logic [ITEM_WIDTH-1:0] cell_item [CAPACITY];
    logic [ITEM_WIDTH-1:0] cell_rd   [CAPACITY];

    assign ctl.ins = s_accept && ins_ok;
    assign ctl.rem = s_accept && rem_ok;
    assign ctl.rd  = s_accept && rd_ok;
    assign ctl.at  = pos - POS_W'(1);

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ITEM_WIDTH-1:0] left_item;
        logic [ITEM_WIDTH-1:0] right_item;

        if (i == 0)
        begin : g_first
            assign left_item = cell_item[i];
        end
        else
        begin : g_mid_l
            assign left_item = cell_item[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_item = cell_item[i];
        end
        else
        begin : g_mid_r
            assign right_item = cell_item[i+1];
        end

        pls_cell #(
            .ITEM_WIDTH (ITEM_WIDTH),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .new_item   (new_item),
            .left_item  (left_item),
            .right_item (right_item),
            .item       (cell_item[i]),
            .rd_item    (cell_rd[i])
        );
    end

    // ---------------- read tree, leaf stage ----------------
    logic [ITEM_WIDTH-1:0] grp_reg [NGRP];

    for (genvar g = 0; g < NGRP; g++)
    begin : g_grp
        logic [ITEM_WIDTH-1:0] part [GROUP];
        logic [ITEM_WIDTH-1:0] grp_or;

        for (genvar j = 0; j < GROUP; j++)
        begin : g_part
            if (g * GROUP + j < CAPACITY)
            begin : g_use
                assign part[j] = cell_rd[g * GROUP + j];
            end
            else
            begin : g_pad
                assign part[j] = '0;
            end
        end

        always_comb
        begin
            grp_or = '0;
            for (int j = 0; j < GROUP; j++)
                grp_or = grp_or | part[j];
        end

        always_ff @(posedge clk)
        begin
            if (s_accept)
                grp_reg[g] <= grp_or;
        end
    end

    // ---------------- pipeline control ----------------
    logic             p1_valid_reg;
    logic             p1_adv;
    status_t          p1_status_reg;
    logic [CNT_W-1:0] p1_len_reg;
    logic             m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [ITEM_WIDTH-1:0] rd_all;

    assign p1_adv   = p1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !p1_valid_reg || p1_adv;

    always_comb
    begin
        rd_all = '0;
        for (int g = 0; g < NGRP; g++)
            rd_all = rd_all | grp_reg[g];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            p1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (s_accept)
                p1_valid_reg <= 1'b1;
            else if (p1_adv)
                p1_valid_reg <= 1'b0;
            if (p1_adv)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            p1_status_reg <= status;
            p1_len_reg    <= cnt_next;
        end
        if (p1_adv)
        begin
            m_tdata_reg <= {(M_TDATA_W - VAL_W - STAT_W - LEN_W)'(0),
                            LEN_W'(p1_len_reg),
                            p1_status_reg,
                            VAL_W'(rd_all)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("list length above capacity");

    a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && ins_ok) |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("insert did not grow the list");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (p1_valid_reg && p1_status_reg == ST_FULL) |-> (p1_len_reg == CNT_W'(CAPACITY)))
        else $error("full status on a list that is not full");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> p1_valid_reg)
        else $error("accepted request lost before the output stage");
`endif

endmodule

[rtl/core/pls_cell.sv]
module pls_cell #(
    parameter int ITEM_WIDTH = pls_pkg::ITEM_WIDTH_DEF,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  pls_pkg::cell_ctl_t    ctl,
    input  logic [ITEM_WIDTH-1:0] new_item,
    input  logic [ITEM_WIDTH-1:0] left_item,   // item of cell INDEX-1
    input  logic [ITEM_WIDTH-1:0] right_item,  // item of cell INDEX+1
    output logic [ITEM_WIDTH-1:0] item,
    output logic [ITEM_WIDTH-1:0] rd_item      // item when read here, else zero
);
    import pls_pkg::*;

    // Cells past the reach of the position field saturate; they are never hit.
    localparam logic [POS_W:0] IDX_SAT = (INDEX >= (1 << POS_W)) ?
                                         (POS_W+1)'(1 << POS_W) : (POS_W+1)'(INDEX);

    logic [ITEM_WIDTH-1:0] item_reg;
    logic [ITEM_WIDTH-1:0] item_next;
    logic [POS_W:0]        at_ext;
    logic                  hit;
    logic                  after;

    assign at_ext = {1'b0, ctl.at};
    assign hit    = (at_ext == IDX_SAT);
    assign after  = (at_ext < IDX_SAT);

    always_comb
    begin
        item_next = item_reg;
        if (ctl.ins)
        begin
            if (hit)
                item_next = new_item;
            else if (after)
                item_next = left_item;
        end
        else if (ctl.rem && (hit || after))
        begin
            item_next = right_item;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item    = item_reg;
    assign rd_item = (ctl.rd && hit) ? item_reg : '0;

endmodule
